@@ src/cch_pkg.sv @@
// ----------------------------------------------------------------------------
// cch_pkg
// Shared types and constants of the three-way cuckoo hash table.
// ----------------------------------------------------------------------------
package cch_pkg;

  localparam int SLOTS_PER_WAY = 1024;
  localparam int NUM_WAYS      = 3;
  localparam int TOTAL_SLOTS   = NUM_WAYS * SLOTS_PER_WAY;
  localparam int IDX_W         = $clog2(SLOTS_PER_WAY);
  localparam int WAY_W         = 2;
  localparam int KEY_W         = 64;
  localparam int VAL_W         = 64;
  localparam int CNT_W         = 12;
  localparam int ROUND_W       = 6;
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);

  localparam logic [63:0] MULT0_RESET = 64'd11400714819323198485;
  localparam logic [63:0] MULT1_RESET = 64'd14029467366897019727;
  localparam logic [63:0] MULT2_RESET = 64'd1609587929392839161;
  localparam logic [ROUND_W-1:0] ROUNDS_RESET = 6'd20;

  typedef enum logic [1:0] {
    REQ_LOOKUP  = 2'd0,
    REQ_INSERT  = 2'd1,
    REQ_REPLACE = 2'd2,
    REQ_REMOVE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_PRESENT  = 2'd2,
    STAT_FULL     = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    REG_MULT0  = 2'd0,
    REG_MULT1  = 2'd1,
    REG_MULT2  = 2'd2,
    REG_ROUNDS = 2'd3
  } reg_t;

  typedef struct packed {
    logic [NUM_WAYS-1:0][63:0] mult;
    logic [ROUND_W-1:0]        rounds;
  } cfg_t;

  typedef struct packed {
    req_t                         kind;
    logic [KEY_W-1:0]             key;
    logic [VAL_W-1:0]             value;
    logic [NUM_WAYS-1:0][IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

endpackage

@@ src/cch_hash.sv @@
// ----------------------------------------------------------------------------
// cch_hash
// Multiply-shift slot hash: low 64 bits of key * multiplier from three
// 32x32 partial products on one multiplier, top bits give the slot index.
// ----------------------------------------------------------------------------
module cch_hash (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [63:0]               key,
  input  logic [63:0]               mult,
  output logic                      done,
  output logic [cch_pkg::IDX_W-1:0] idx
);

  logic [63:0] a;
  logic [63:0] b;
  logic [1:0]  cnt;
  logic        busy;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  // pick the partial product of this pass
  always_comb begin
    case (cnt)
      2'd0: begin
        mul_a = a[31:0];
        mul_b = b[31:0];
      end
      2'd1: begin
        mul_a = a[31:0];
        mul_b = b[63:32];
      end
      default: begin
        mul_a = a[63:32];
        mul_b = b[31:0];
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign idx   = acc[63 -: cch_pkg::IDX_W];

  // run four passes: three products, then the last sum
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a    <= key;
        b    <= mult;
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        case (cnt)
          2'd0: prod <= mul_p;
          2'd1: begin
            prod <= mul_p;
            acc  <= prod;
          end
          2'd2: begin
            prod <= mul_p;
            acc  <= acc + {prod[31:0], 32'd0};
          end
          default: begin
            acc  <= acc + {prod[31:0], 32'd0};
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule

@@ src/cch_queue.sv @@
// ----------------------------------------------------------------------------
// cch_queue
// Short command queue between the hashing front and the table back.
// ----------------------------------------------------------------------------
module cch_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cch_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output cch_pkg::cmd_t head,
  output logic          empty
);

  cch_pkg::cmd_t                ent [cch_pkg::Q_DEPTH];
  logic [cch_pkg::Q_PTR_W-1:0]  wptr;
  logic [cch_pkg::Q_PTR_W-1:0]  rptr;
  logic [cch_pkg::Q_PTR_W:0]    cnt;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (cnt == (cch_pkg::Q_PTR_W+1)'(cch_pkg::Q_DEPTH));
  assign empty   = (cnt == '0);
  assign head    = ent[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wptr] <= push_data;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

@@ src/cch_front.sv @@
// ----------------------------------------------------------------------------
// cch_front
// Front end: accept a request, hash its key for all three ways at once and
// hand the command to the queue.
// ----------------------------------------------------------------------------
module cch_front (
  input  logic                 clk,
  input  logic                 rst,
  input  cch_pkg::cfg_t        cfg,
  input  logic                 clearing,
  input  logic                 push,
  input  logic [1:0]           req_type,
  input  logic [63:0]          req_key,
  input  logic [63:0]          req_value,
  output logic                 full,
  input  logic                 q_full,
  output logic                 q_push,
  output cch_pkg::cmd_t        q_data
);

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} state_t;

  state_t                                      state;
  cch_pkg::cmd_t                               cur;
  logic                                        accept;
  logic [cch_pkg::NUM_WAYS-1:0]                h_done;
  logic [cch_pkg::NUM_WAYS-1:0][cch_pkg::IDX_W-1:0] h_idx;

  assign full   = (state != F_IDLE) || clearing;
  assign accept = push && !full;
  assign q_push = (state == F_PUSH) && !q_full;
  assign q_data = cur;

  // one hash unit per way
  for (genvar w = 0; w < cch_pkg::NUM_WAYS; w++) begin : g_hash
    cch_hash u_hash (
      .clk   (clk),
      .rst   (rst),
      .start (accept),
      .key   (req_key),
      .mult  (cfg.mult[w]),
      .done  (h_done[w]),
      .idx   (h_idx[w])
    );
  end

  // hold the request until its command is queued
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            cur.kind  <= cch_pkg::req_t'(req_type);
            cur.key   <= req_key;
            cur.value <= req_value;
            state     <= F_HASH;
          end
        end
        F_HASH: begin
          if (&h_done) begin
            cur.idx <= h_idx;
            state   <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

@@ src/cch_back.sv @@
// ----------------------------------------------------------------------------
// cch_back
// Back end: owns the slot store, checks the three candidate slots, updates,
// runs the displacement walk and holds the result for the consumer.
// ----------------------------------------------------------------------------
module cch_back (
  input  logic                         clk,
  input  logic                         rst,
  input  cch_pkg::cfg_t                cfg,
  input  logic                         q_empty,
  input  cch_pkg::cmd_t                q_head,
  output logic                         q_pop,
  output logic                         clearing,
  input  logic                         pop,
  output logic                         out_valid,
  output logic [1:0]                   status,
  output logic [63:0]                  found_value,
  output logic [63:0]                  spill_key,
  output logic [63:0]                  spill_value,
  output logic [cch_pkg::CNT_W-1:0]    entry_count
);

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_CHECK, B_HASH, B_WALK} state_t;

  state_t                                state;
  logic [cch_pkg::IDX_W-1:0]             clr_addr;
  cch_pkg::cmd_t                         cur;
  logic [63:0]                           carry_key;
  logic [63:0]                           carry_value;
  logic [cch_pkg::WAY_W-1:0]             way;
  logic [cch_pkg::WAY_W-1:0]             next_way;
  logic [cch_pkg::ROUND_W-1:0]           round;
  logic [cch_pkg::IDX_W-1:0]             walk_idx;
  logic [cch_pkg::CNT_W-1:0]             entry_cnt;

  cch_pkg::slot_t                        mem0 [cch_pkg::SLOTS_PER_WAY];
  cch_pkg::slot_t                        mem1 [cch_pkg::SLOTS_PER_WAY];
  cch_pkg::slot_t                        mem2 [cch_pkg::SLOTS_PER_WAY];
  cch_pkg::slot_t                        rd [cch_pkg::NUM_WAYS];
  logic [cch_pkg::NUM_WAYS-1:0][cch_pkg::IDX_W-1:0] raddr;
  logic [cch_pkg::NUM_WAYS-1:0]          wr_en;
  logic [cch_pkg::IDX_W-1:0]             wr_addr;
  cch_pkg::slot_t                        wr_data;

  logic [cch_pkg::NUM_WAYS-1:0]          hit;
  logic                                  any_hit;
  logic [cch_pkg::WAY_W-1:0]             hit_way;
  logic                                  last;

  cch_pkg::stat_t                        chk_status;
  logic [63:0]                           chk_found;
  logic                                  chk_spill;
  logic [cch_pkg::CNT_W-1:0]             chk_count;
  logic                                  chk_walk;

  logic                                  hs_start;
  logic [63:0]                           hs_key;
  logic [63:0]                           hs_mult;
  logic                                  hs_done;
  logic [cch_pkg::IDX_W-1:0]             hs_idx;

  assign clearing = (state == B_CLEAR);
  assign next_way = (way == cch_pkg::WAY_W'(cch_pkg::NUM_WAYS - 1)) ? '0 : way + 1'b1;
  assign last     = (way == cch_pkg::WAY_W'(cch_pkg::NUM_WAYS - 1)) &&
                    ({1'b0, round} + 7'd1 == {1'b0, cfg.rounds});

  // slot hash for carried keys
  cch_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hs_start),
    .key   (hs_key),
    .mult  (hs_mult),
    .done  (hs_done),
    .idx   (hs_idx)
  );

  // match candidate slots, first way wins
  always_comb begin
    for (int w = 0; w < cch_pkg::NUM_WAYS; w++) begin
      hit[w] = rd[w].valid && (rd[w].key == cur.key);
    end
    any_hit = |hit;
    hit_way = '0;
    for (int w = cch_pkg::NUM_WAYS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        hit_way = cch_pkg::WAY_W'(w);
      end
    end
  end

  // decide the outcome of a checked request
  always_comb begin
    chk_status = cch_pkg::STAT_DONE;
    chk_found  = '0;
    chk_spill  = 1'b0;
    chk_count  = entry_cnt;
    chk_walk   = 1'b0;
    case (cur.kind)
      cch_pkg::REQ_LOOKUP: begin
        if (any_hit) begin
          chk_found = rd[hit_way].value;
        end else begin
          chk_status = cch_pkg::STAT_NOTFOUND;
        end
      end
      cch_pkg::REQ_REPLACE: begin
        if (!any_hit) begin
          chk_status = cch_pkg::STAT_NOTFOUND;
        end
      end
      cch_pkg::REQ_REMOVE: begin
        if (any_hit) begin
          chk_count = entry_cnt - 1'b1;
        end else begin
          chk_status = cch_pkg::STAT_NOTFOUND;
        end
      end
      default: begin
        if (any_hit) begin
          chk_status = cch_pkg::STAT_PRESENT;
        end else if (cfg.rounds == '0) begin
          chk_status = cch_pkg::STAT_FULL;
          chk_spill  = 1'b1;
        end else begin
          chk_walk = 1'b1;
        end
      end
    endcase
  end

  // memory addresses, writes and hash requests
  always_comb begin
    q_pop    = 1'b0;
    wr_en    = '0;
    wr_addr  = clr_addr;
    wr_data  = '0;
    hs_start = 1'b0;
    hs_key   = cur.key;
    hs_mult  = cfg.mult[0];
    for (int w = 0; w < cch_pkg::NUM_WAYS; w++) begin
      raddr[w] = hs_idx;
    end
    case (state)
      B_CLEAR: begin
        wr_en = '1;
      end
      B_IDLE: begin
        q_pop = !q_empty && !out_valid;
        raddr = q_head.idx;
      end
      B_CHECK: begin
        wr_addr = cur.idx[hit_way];
        if (any_hit && cur.kind == cch_pkg::REQ_REPLACE) begin
          wr_en[hit_way] = 1'b1;
          wr_data        = '{valid: 1'b1, key: cur.key, value: cur.value};
        end else if (any_hit && cur.kind == cch_pkg::REQ_REMOVE) begin
          wr_en[hit_way] = 1'b1;
          wr_data        = '{valid: 1'b0, key: cur.key, value: cur.value};
        end else if (chk_walk) begin
          hs_start = 1'b1;
        end
      end
      B_WALK: begin
        wr_en[way] = 1'b1;
        wr_addr    = walk_idx;
        wr_data    = '{valid: 1'b1, key: carry_key, value: carry_value};
        if (rd[way].valid && !last) begin
          hs_start = 1'b1;
          hs_key   = rd[way].key;
          hs_mult  = cfg.mult[next_way];
        end
      end
      default: ;
    endcase
  end

  // slot store, registered reads
  always_ff @(posedge clk) begin
    if (wr_en[0]) begin
      mem0[wr_addr] <= wr_data;
    end
    if (wr_en[1]) begin
      mem1[wr_addr] <= wr_data;
    end
    if (wr_en[2]) begin
      mem2[wr_addr] <= wr_data;
    end
    rd[0] <= mem0[raddr[0]];
    rd[1] <= mem1[raddr[1]];
    rd[2] <= mem2[raddr[2]];
  end

  // sequence clear, check and walk; hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      entry_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == cch_pkg::IDX_W'(cch_pkg::SLOTS_PER_WAY - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_pop) begin
            cur   <= q_head;
            state <= B_CHECK;
          end
        end
        B_CHECK: begin
          if (chk_walk) begin
            carry_key   <= cur.key;
            carry_value <= cur.value;
            way         <= '0;
            round       <= '0;
            state       <= B_HASH;
          end else begin
            found_value <= chk_found;
            spill_key   <= chk_spill ? cur.key : '0;
            spill_value <= chk_spill ? cur.value : '0;
            entry_cnt   <= chk_count;
            entry_count <= chk_count;
            status      <= chk_status;
            out_valid   <= 1'b1;
            state       <= B_IDLE;
          end
        end
        B_HASH: begin
          if (hs_done) begin
            walk_idx <= hs_idx;
            state    <= B_WALK;
          end
        end
        B_WALK: begin
          if (!rd[way].valid) begin
            entry_cnt   <= entry_cnt + 1'b1;
            entry_count <= entry_cnt + 1'b1;
            status      <= cch_pkg::STAT_DONE;
            found_value <= '0;
            spill_key   <= '0;
            spill_value <= '0;
            out_valid   <= 1'b1;
            state       <= B_IDLE;
          end else if (last) begin
            entry_count <= entry_cnt;
            status      <= cch_pkg::STAT_FULL;
            found_value <= '0;
            spill_key   <= rd[way].key;
            spill_value <= rd[way].value;
            out_valid   <= 1'b1;
            state       <= B_IDLE;
          end else begin
            carry_key   <= rd[way].key;
            carry_value <= rd[way].value;
            way         <= next_way;
            if (way == cch_pkg::WAY_W'(cch_pkg::NUM_WAYS - 1)) begin
              round <= round + 1'b1;
            end
            state <= B_HASH;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // count never exceeds the slot total
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    entry_cnt <= cch_pkg::CNT_W'(cch_pkg::TOTAL_SLOTS))
    else $error("entry count beyond slot total");

  // outside the clearing pass only one way is written per cycle
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    state != B_CLEAR |-> $onehot0(wr_en))
    else $error("more than one way written");

  // a command is taken only when the result register is free
  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !out_valid)
    else $error("command taken while result pending");

  // a walk step writes back only after its hash was done
  a_walk_hash: assert property (@(posedge clk) disable iff (rst)
    state == B_WALK |-> $past(hs_done))
    else $error("walk step without hash");

endmodule

@@ src/three_way_cuckoo_hash_table.sv @@
// ----------------------------------------------------------------------------
// three_way_cuckoo_hash_table
// Three-way cuckoo hash table of 64-bit keys and values with lookup, insert,
// replace and remove, a configurable displacement walk and an APB port.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the 1024 slots of each
// way of the slot store, during which full stays high. For a request, the
// front hashes the key for all three ways in four passes of a 32x32
// multiplier per way, and the back reads the three candidate slots and
// decides. Each displacement of an insert takes four hash passes on the
// back's own multiplier, one slot read and one write; an insert walks at
// most 3 * displacement_rounds slots. The front takes the next request
// while the back still works or a result waits to be popped, as long as
// the command queue has room.
module three_way_cuckoo_hash_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [63:0] req_key,
  input  logic [63:0] req_value,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [63:0] found_value,
  output logic [63:0] spill_key,
  output logic [63:0] spill_value,
  output logic [11:0] entry_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cch_pkg::cfg_t  cfg;
  cch_pkg::reg_t  reg_sel;
  logic           cfg_wr;
  logic           front_full;
  logic           clearing;
  logic           q_full;
  logic           q_push;
  cch_pkg::cmd_t  q_data;
  logic           q_pop;
  logic           q_empty;
  cch_pkg::cmd_t  q_head;
  logic           out_valid;

  assign pready  = 1'b1;
  assign reg_sel = cch_pkg::reg_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign full    = front_full;
  assign empty   = !out_valid;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mult[0] <= cch_pkg::MULT0_RESET;
      cfg.mult[1] <= cch_pkg::MULT1_RESET;
      cfg.mult[2] <= cch_pkg::MULT2_RESET;
      cfg.rounds  <= cch_pkg::ROUNDS_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        cch_pkg::REG_MULT0:  cfg.mult[0] <= pwdata;
        cch_pkg::REG_MULT1:  cfg.mult[1] <= pwdata;
        cch_pkg::REG_MULT2:  cfg.mult[2] <= pwdata;
        cch_pkg::REG_ROUNDS: cfg.rounds  <= pwdata[cch_pkg::ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  // read back configuration registers
  always_comb begin
    case (reg_sel)
      cch_pkg::REG_MULT0:  prdata = cfg.mult[0];
      cch_pkg::REG_MULT1:  prdata = cfg.mult[1];
      cch_pkg::REG_MULT2:  prdata = cfg.mult[2];
      cch_pkg::REG_ROUNDS: prdata = {{(64 - cch_pkg::ROUND_W){1'b0}}, cfg.rounds};
      default:             prdata = '0;
    endcase
  end

  cch_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clearing  (clearing),
    .push      (push),
    .req_type  (req_type),
    .req_key   (req_key),
    .req_value (req_value),
    .full      (front_full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  cch_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  cch_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .pop         (pop),
    .out_valid   (out_valid),
    .status      (status),
    .found_value (found_value),
    .spill_key   (spill_key),
    .spill_value (spill_value),
    .entry_count (entry_count)
  );

endmodule
